>>> rtl/palette_color_map_core_defines.svh
`ifndef PALETTE_COLOR_MAP_CORE_DEFINES_SVH
`define PALETTE_COLOR_MAP_CORE_DEFINES_SVH

// same-cycle implication
`define PCM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcm check failed");

// next-cycle implication
`define PCM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcm check failed");

`endif

>>> rtl/pcm_pkg.sv
package pcm_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int FRACTION_BITS = 8;
   localparam int MAX_COLORS    = 4;
   localparam int PALETTE_SLOTS = 4;
   localparam int COLOR_LIMIT   = (MAX_COLORS < PALETTE_SLOTS) ? MAX_COLORS : PALETTE_SLOTS;

   localparam int SLOT_BITS  = $clog2(PALETTE_SLOTS);
   localparam int QUO_BITS   = FRACTION_BITS + SLOT_BITS;
   localparam int ND_BITS    = SAMPLE_BITS + SLOT_BITS;
   localparam int CHAN_BITS  = 8;
   localparam int COLOR_BITS = 3 * CHAN_BITS;
   localparam int COUNT_BITS = 3;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = (SAMPLE_BITS > COLOR_BITS) ? SAMPLE_BITS : COLOR_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_LOW   = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_HIGH  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_COUNT = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_MODE  = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_ZERO  = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_ONE   = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_TWO   = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_THREE = 4'd7;

   localparam int RANGE_HIGH_RESET  = 32767;
   localparam int COLOR_COUNT_RESET = 4;
   localparam logic [COLOR_BITS-1:0] COLOR_ZERO_RESET  = 24'h000077;
   localparam logic [COLOR_BITS-1:0] COLOR_ONE_RESET   = 24'h0000FF;
   localparam logic [COLOR_BITS-1:0] COLOR_TWO_RESET   = 24'hFF0000;
   localparam logic [COLOR_BITS-1:0] COLOR_THREE_RESET = 24'hFFFF00;

   localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef logic [PALETTE_SLOTS-1:0][COLOR_BITS-1:0] palette_type;

   typedef struct packed {
      logic                   valid;
      logic                   empty;
      logic [SAMPLE_BITS-1:0] rem;
      logic [QUO_BITS-1:0]    num;
      logic [QUO_BITS-1:0]    quo;
   } div_type;

endpackage

>>> rtl/pcm_front.sv
module pcm_front
   import pcm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic signed [SAMPLE_BITS-1:0] range_low,
   input  logic signed [SAMPLE_BITS-1:0] range_high,
   input  logic        [SLOT_BITS-1:0]   step,
   input  logic                          hold_dn,
   output logic                          req_stall,
   output div_type                       div_out
);

   logic                          clamp_valid_ff;
   logic                          clamp_empty_ff;
   logic signed [SAMPLE_BITS-1:0] clamp_value_ff;
   logic signed [SAMPLE_BITS-1:0] clamp_value_in;
   logic signed [SAMPLE_BITS-1:0] high_m1;
   logic                          hold_clamp;
   logic                          hold_scale;
   logic        [SAMPLE_BITS:0]   diff;
   logic        [ND_BITS-1:0]     scaled;
   div_type                       div_ff;
   div_type                       div_in;

   assign hold_scale = div_ff.valid & hold_dn;
   assign hold_clamp = clamp_valid_ff & hold_scale;
   assign req_stall  = hold_clamp;

   assign high_m1 = range_high - SAMPLE_BITS'(1);

   always_comb begin
      if (req_sample < range_low) begin
         clamp_value_in = range_low;
      end else if (req_sample > high_m1) begin
         clamp_value_in = high_m1;
      end else begin
         clamp_value_in = req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_valid_ff <= 1'b0;
      end else if (!hold_clamp) begin
         clamp_valid_ff <= req_valid;
      end
      if (!hold_clamp) begin
         clamp_value_ff <= clamp_value_in;
         clamp_empty_ff <= (range_low >= range_high);
      end
   end

   assign diff   = {clamp_value_ff[SAMPLE_BITS-1], clamp_value_ff}
                 - {range_low[SAMPLE_BITS-1], range_low};
   assign scaled = ND_BITS'(diff[SAMPLE_BITS-1:0]) * ND_BITS'(step);

   always_comb begin
      div_in.valid = clamp_valid_ff;
      div_in.empty = clamp_empty_ff;
      div_in.rem   = scaled[ND_BITS-1:SLOT_BITS];
      div_in.num   = {scaled[SLOT_BITS-1:0], FRACTION_BITS'(0)};
      div_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else if (!hold_scale) begin
         div_ff <= div_in;
      end
   end

   assign div_out = div_ff;

endmodule

>>> rtl/pcm_div_cell.sv
module pcm_div_cell
   import pcm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SAMPLE_BITS-1:0] span,
   input  div_type                cell_in,
   input  logic                   hold_dn,
   output logic                   hold_up,
   output div_type                cell_out
);

   div_type                cell_ff;
   div_type                cell_next;
   logic [SAMPLE_BITS:0]   trial;
   logic [SAMPLE_BITS:0]   trial_sub;
   logic                   fits;

   assign hold_up   = cell_ff.valid & hold_dn;
   assign trial     = {cell_in.rem, cell_in.num[QUO_BITS-1]};
   assign trial_sub = trial - {1'b0, span};
   assign fits      = (trial >= {1'b0, span});

   always_comb begin
      cell_next       = cell_in;
      cell_next.rem   = fits ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
      cell_next.num   = {cell_in.num[QUO_BITS-2:0], 1'b0};
      cell_next.quo   = {cell_in.quo[QUO_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (!hold_up) begin
         cell_ff <= cell_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/pcm_blend.sv
module pcm_blend
   import pcm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  div_type              div_in,
   input  palette_type          palette,
   input  logic [SLOT_BITS-1:0] step,
   input  logic                 alpha_mode,
   input  logic                 rsp_stall,
   output logic                 hold_up,
   output logic                 rsp_valid,
   output logic [CHAN_BITS-1:0] rsp_red,
   output logic [CHAN_BITS-1:0] rsp_green,
   output logic [CHAN_BITS-1:0] rsp_blue,
   output logic [CHAN_BITS-1:0] rsp_alpha
);

   localparam int PROD_BITS = FRACTION_BITS + 1 + CHAN_BITS;

   logic                         rsp_valid_ff;
   logic [CHAN_BITS-1:0]         red_ff, green_ff, blue_ff, alpha_ff;
   logic [CHAN_BITS-1:0]         chan_in [3];
   logic [CHAN_BITS-1:0]         alpha_in;
   logic [FRACTION_BITS-1:0]     frac;
   logic [FRACTION_BITS:0]       frac_inv;
   logic [SLOT_BITS-1:0]         idx_raw;
   logic [SLOT_BITS-1:0]         idx_max;
   logic [SLOT_BITS-1:0]         idx_a;
   logic [SLOT_BITS-1:0]         idx_b;
   logic [COLOR_BITS-1:0]        color_a;
   logic [COLOR_BITS-1:0]        color_b;
   logic [PROD_BITS-1:0]         mix;
   logic [FRACTION_BITS+CHAN_BITS-1:0] alpha_prod;

   assign hold_up = rsp_valid_ff & rsp_stall;

   assign frac     = div_in.quo[FRACTION_BITS-1:0];
   assign frac_inv = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - {1'b0, frac};
   assign idx_raw  = div_in.quo[QUO_BITS-1:FRACTION_BITS];
   assign idx_max  = step - SLOT_BITS'(1);
   assign idx_a    = (idx_raw > idx_max) ? idx_max : idx_raw;
   assign idx_b    = idx_a + SLOT_BITS'(1);
   assign color_a  = palette[idx_a];
   assign color_b  = palette[idx_b];

   assign alpha_prod = {frac, CHAN_BITS'(0)} - (FRACTION_BITS+CHAN_BITS)'(frac);

   always_comb begin
      mix = '0;
      for (int k = 0; k < 3; k++) begin
         mix = PROD_BITS'(frac_inv) * PROD_BITS'(color_a[(2-k)*CHAN_BITS +: CHAN_BITS])
             + PROD_BITS'(frac) * PROD_BITS'(color_b[(2-k)*CHAN_BITS +: CHAN_BITS]);
         if (div_in.empty) begin
            chan_in[k] = palette[0][(2-k)*CHAN_BITS +: CHAN_BITS];
         end else begin
            chan_in[k] = mix[FRACTION_BITS +: CHAN_BITS];
         end
      end
      if (alpha_mode && !div_in.empty) begin
         alpha_in = alpha_prod[FRACTION_BITS +: CHAN_BITS];
      end else begin
         alpha_in = ALPHA_OPAQUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!hold_up) begin
         rsp_valid_ff <= div_in.valid;
      end
      if (!hold_up) begin
         red_ff   <= chan_in[0];
         green_ff <= chan_in[1];
         blue_ff  <= chan_in[2];
         alpha_ff <= alpha_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;
   assign rsp_alpha = alpha_ff;

endmodule

>>> rtl/palette_color_map_core.sv
// False-color mapper: takes one signed sample per clock while req_stall is low and returns
// one RGBA response per sample, blended between two neighboring palette entries over
// [range_low, range_high), or entry 0 for an empty range. Throughput is one request per
// cycle unless rsp_stall holds the pipeline. Stages: clamp, scale, a chain of
// restoring-divider cells that each settle one quotient bit and pass the partial remainder
// on every unstalled cycle, and the blend stage with the result register. req_stall rises
// only while a result is held by rsp_stall and every stage behind it is occupied. Write the registers only while idle.
`include "palette_color_map_core_defines.svh"

module palette_color_map_core
   import pcm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic        [CHAN_BITS-1:0]   rsp_red,
   output logic        [CHAN_BITS-1:0]   rsp_green,
   output logic        [CHAN_BITS-1:0]   rsp_blue,
   output logic        [CHAN_BITS-1:0]   rsp_alpha,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic        [CSR_INDEX_BITS-1:0] csr_index,
   input  logic        [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic signed [SAMPLE_BITS-1:0] range_low_ff;
   logic signed [SAMPLE_BITS-1:0] range_high_ff;
   logic        [COUNT_BITS-1:0]  count_ff;
   logic                          alpha_mode_ff;
   palette_type                   palette_ff;

   logic [COUNT_BITS-1:0]  count_eff;
   logic [SLOT_BITS-1:0]   step;
   logic [SAMPLE_BITS-1:0] span;
   logic                   range_empty;
   logic                   rsp_opaque;

   div_type div_chain  [QUO_BITS+1];
   logic    hold_chain [QUO_BITS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= SAMPLE_BITS'(RANGE_HIGH_RESET);
         count_ff      <= COUNT_BITS'(COLOR_COUNT_RESET);
         alpha_mode_ff <= 1'b0;
         palette_ff[0] <= COLOR_ZERO_RESET;
         palette_ff[1] <= COLOR_ONE_RESET;
         palette_ff[2] <= COLOR_TWO_RESET;
         palette_ff[3] <= COLOR_THREE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RANGE_LOW:   range_low_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_RANGE_HIGH:  range_high_ff <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_COLOR_COUNT: count_ff      <= csr_wdata[COUNT_BITS-1:0];
            CSR_ALPHA_MODE:  alpha_mode_ff <= csr_wdata[0];
            CSR_COLOR_ZERO:  palette_ff[0] <= csr_wdata[COLOR_BITS-1:0];
            CSR_COLOR_ONE:   palette_ff[1] <= csr_wdata[COLOR_BITS-1:0];
            CSR_COLOR_TWO:   palette_ff[2] <= csr_wdata[COLOR_BITS-1:0];
            CSR_COLOR_THREE: palette_ff[3] <= csr_wdata[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (count_ff < COUNT_BITS'(2)) begin
         count_eff = COUNT_BITS'(2);
      end else if (count_ff > COUNT_BITS'(COLOR_LIMIT)) begin
         count_eff = COUNT_BITS'(COLOR_LIMIT);
      end else begin
         count_eff = count_ff;
      end
   end

   assign step = SLOT_BITS'(count_eff - COUNT_BITS'(1));
   assign span = range_high_ff - range_low_ff;

   pcm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_sample (req_sample),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .step       (step),
      .hold_dn    (hold_chain[0]),
      .req_stall  (req_stall),
      .div_out    (div_chain[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      pcm_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .span     (span),
         .cell_in  (div_chain[i]),
         .hold_dn  (hold_chain[i+1]),
         .hold_up  (hold_chain[i]),
         .cell_out (div_chain[i+1])
      );
   end

   pcm_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .div_in     (div_chain[QUO_BITS]),
      .palette    (palette_ff),
      .step       (step),
      .alpha_mode (alpha_mode_ff),
      .rsp_stall  (rsp_stall),
      .hold_up    (hold_chain[QUO_BITS]),
      .rsp_valid  (rsp_valid),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue),
      .rsp_alpha  (rsp_alpha)
   );

   assign range_empty = (range_low_ff >= range_high_ff);
   assign rsp_opaque  = (rsp_alpha == ALPHA_OPAQUE);

   `PCM_ASSERT_IMP(a_stall_from_output, clock, reset, req_stall, rsp_valid && rsp_stall)
   `PCM_ASSERT_NXT(a_stall_keeps_result, clock, reset, req_stall, rsp_valid)
   `PCM_ASSERT_IMP(a_empty_opaque, clock, reset, rsp_valid && range_empty, rsp_opaque)
   `PCM_ASSERT_IMP(a_mode_opaque, clock, reset, rsp_valid && !alpha_mode_ff, rsp_opaque)

endmodule
